// ===== design/crcpr_pkg.sv =====
// shared types, codes and crc helpers for the framed packet receiver
// no dependencies; imported by crc_framed_packet_receiver
package crcpr_pkg;

    localparam int unsigned BYTE_W       = 8;
    localparam int unsigned CRC_W        = 16;
    localparam int unsigned CFG_IDX_W    = 3;
    localparam int unsigned CFG_DATA_W   = 16;
    localparam int unsigned OUT_TDATA_W  = 80;
    localparam int unsigned OUT_PAD_W    = 5;

    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [CRC_W-1:0]  t_crc;

    // frame constants
    localparam t_byte MARK_FIRST  = 8'hAA;
    localparam t_byte MARK_SECOND = 8'h55;
    localparam t_byte TYPE_MIN    = 8'h01;
    localparam t_byte TYPE_MAX    = 8'h06;

    // register reset values
    localparam t_byte    RST_MAX_ARGS    = 8'd8;
    localparam t_byte    RST_MAX_PAYLOAD = 8'd64;
    localparam t_crc     RST_TIMEOUT     = 16'd100;
    localparam t_crc     RST_CRC_POLY    = 16'h8005;
    localparam t_crc     RST_CRC_INIT    = 16'h0000;
    localparam t_crc     RST_CRC_XOROUT  = 16'h0000;
    localparam logic [1:0] RST_CRC_REFLECT = 2'b00;

    localparam t_crc TICKS_SAT = 16'hFFFF;

    // request kinds on the input side
    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_ARGS    = 3'd0,
        CFG_MAX_PAYLOAD = 3'd1,
        CFG_TIMEOUT     = 3'd2,
        CFG_CRC_POLY    = 3'd3,
        CFG_CRC_INIT    = 3'd4,
        CFG_CRC_XOROUT  = 3'd5,
        CFG_CRC_REFLECT = 3'd6
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BAD_MARKER = 3'd1,
        ST_MANY_ARGS  = 3'd2,
        ST_BAD_TYPE   = 3'd3,
        ST_LONG_PAY   = 3'd4,
        ST_CRC_ERR    = 3'd5,
        ST_TIMEOUT    = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        KIND_TYPE    = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_DONE    = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind   kind;
        t_crc    crc_computed;
        t_crc    crc_received;
        t_byte   pay_len;
        t_byte   arg_count;
        t_byte   command;
        t_status status;
        t_byte   position;
        t_byte   value;
    } t_result;

    function automatic t_byte reflect8(input t_byte v);
        t_byte r;
        for (int i = 0; i < BYTE_W; i++) begin
            r[i] = v[BYTE_W-1-i];
        end
        return r;
    endfunction

    function automatic t_crc reflect16(input t_crc v);
        t_crc r;
        for (int i = 0; i < CRC_W; i++) begin
            r[i] = v[CRC_W-1-i];
        end
        return r;
    endfunction

    // one byte through the msb-first crc shift register
    function automatic t_crc crc_absorb(input t_crc crc, input t_byte data,
                                        input t_crc poly, input logic refl_in);
        t_crc  c;
        t_byte d;
        d = refl_in ? reflect8(data) : data;
        c = crc ^ {d, 8'h00};
        for (int i = 0; i < BYTE_W; i++) begin
            c = c[CRC_W-1] ? ({c[CRC_W-2:0], 1'b0} ^ poly) : {c[CRC_W-2:0], 1'b0};
        end
        return c;
    endfunction

    function automatic t_crc crc_final(input t_crc crc, input t_crc xorout,
                                       input logic refl_out);
        t_crc c;
        c = refl_out ? reflect16(crc) : crc;
        return c ^ xorout;
    endfunction

endpackage

// ===== design/crc_framed_packet_receiver.sv =====
// framed packet receiver: parses AA 55 framed packets a byte per request
// depends on crcpr_pkg (types, codes, crc helpers)
//
// usage
//  - input stream (s_axis_*): one request per handshake; tuser 0 carries a
//    received byte in tdata, tuser 1 is a timer tick (tdata ignored)
//  - output stream (m_axis_*): argument type bytes, payload bytes and one
//    frame-finished result with a status; tuser holds the result kind
//  - config channel (i_cfg_*): register index and write data, always ready,
//    meant to be used while no request is in flight
//  - each request is decoded in the cycle it is accepted; its result is
//    registered in the output register, or in the skid while one waits
//  - throughput is one request per cycle while the skid is empty; the byte-wide crc update is a
//    single unrolled 8-step shift, the second marker byte uses a crc value
//    pre-absorbed over the first marker from the current init setting
//  - a skid register behind the output register keeps the input open for
//    one more request while a result waits; s_axis_tready is low while the
//    skid holds a result and comes back the cycle after the next pop
//  - reset (synchronous, active low) returns to idle with default settings
//    and empties the output side
module crc_framed_packet_receiver
    import crcpr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [BYTE_W-1:0]     s_axis_tdata,   // rx_byte[7:0]
    input  logic [0:0]            s_axis_tuser,   // req_type[0]
    // output stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // value[7:0], position[15:8], status[18:16], command[26:19],
    // arg_count[34:27], pay_len[42:35], crc_received[58:43],
    // crc_computed[74:59], zero[79:75]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic [1:0]            m_axis_tuser,   // kind[1:0]
    // config writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_MARK2   = 4'd1,
        PH_CMD     = 4'd2,
        PH_COUNT   = 4'd3,
        PH_TYPES   = 4'd4,
        PH_LEN     = 4'd5,
        PH_PAYLOAD = 4'd6,
        PH_CRC_HI  = 4'd7,
        PH_CRC_LO  = 4'd8
    } t_phase;

    // configuration
    t_byte      r_max_args, n_max_args;
    t_byte      r_max_payload, n_max_payload;
    t_crc       r_timeout, n_timeout;
    t_crc       r_crc_poly, n_crc_poly;
    t_crc       r_crc_init, n_crc_init;
    t_crc       r_crc_xorout, n_crc_xorout;
    logic [1:0] r_crc_reflect, n_crc_reflect;
    t_crc       r_crc_aa;     // init already run over the first marker

    // frame state
    t_phase r_phase, n_phase;
    t_byte  r_first_marker, n_first_marker;
    t_crc   r_crc, n_crc;
    t_byte  r_cmd, n_cmd;
    t_byte  r_count, n_count;
    t_byte  r_length, n_length;
    t_byte  r_index, n_index;
    t_byte  r_crc_hi, n_crc_hi;
    t_crc   r_idle_ticks, n_idle_ticks;

    // output register and skid
    logic    r_out_valid, n_out_valid;
    t_result r_out, n_out;
    logic    r_skid_valid, n_skid_valid;
    t_result r_skid, n_skid;

    logic    accept;
    logic    pop;
    logic    res_valid;
    t_result res;
    t_byte   rx;
    t_byte   index_inc;
    t_crc    ticks_inc;
    t_crc    crc_rx;
    t_crc    crc_calc;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = ~r_skid_valid;
    assign accept        = s_axis_tvalid & s_axis_tready;
    assign pop           = r_out_valid & m_axis_tready;
    assign rx            = s_axis_tdata;
    assign index_inc     = r_index + 8'd1;
    assign ticks_inc     = (r_idle_ticks != TICKS_SAT) ? r_idle_ticks + 16'd1 : r_idle_ticks;
    assign crc_rx        = {r_crc_hi, rx};
    assign crc_calc      = crc_final(r_crc, r_crc_xorout, r_crc_reflect[1]);

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, r_out.crc_computed, r_out.crc_received,
                            r_out.pay_len, r_out.arg_count, r_out.command,
                            r_out.status, r_out.position, r_out.value};

    // register writes
    always_comb begin
        n_max_args    = r_max_args;
        n_max_payload = r_max_payload;
        n_timeout     = r_timeout;
        n_crc_poly    = r_crc_poly;
        n_crc_init    = r_crc_init;
        n_crc_xorout  = r_crc_xorout;
        n_crc_reflect = r_crc_reflect;
        if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_MAX_ARGS:    n_max_args    = i_cfg_data[BYTE_W-1:0];
                CFG_MAX_PAYLOAD: n_max_payload = i_cfg_data[BYTE_W-1:0];
                CFG_TIMEOUT:     n_timeout     = i_cfg_data;
                CFG_CRC_POLY:    n_crc_poly    = i_cfg_data;
                CFG_CRC_INIT:    n_crc_init    = i_cfg_data;
                CFG_CRC_XOROUT:  n_crc_xorout  = i_cfg_data;
                CFG_CRC_REFLECT: n_crc_reflect = i_cfg_data[1:0];
                default: ;  // index beyond the register list is dropped
            endcase
        end
    end

    // frame parser: one request per cycle while s_axis_tready is high
    always_comb begin
        n_phase        = r_phase;
        n_first_marker = r_first_marker;
        n_crc          = r_crc;
        n_cmd          = r_cmd;
        n_count        = r_count;
        n_length       = r_length;
        n_index        = r_index;
        n_crc_hi       = r_crc_hi;
        n_idle_ticks   = r_idle_ticks;
        res_valid      = 1'b0;
        res            = '0;
        res.kind       = KIND_DONE;
        res.status     = ST_OK;

        if (accept) begin
            if (s_axis_tuser[0] == REQ_TICK) begin
                // ticks only count inside a frame
                if (r_phase != PH_IDLE) begin
                    n_idle_ticks = ticks_inc;
                    if (ticks_inc >= r_timeout) begin
                        res_valid    = 1'b1;
                        res.status   = ST_TIMEOUT;
                        n_phase      = PH_IDLE;
                        n_idle_ticks = '0;
                    end
                end
            end else begin
                n_idle_ticks = '0;
                unique case (r_phase)
                    PH_IDLE: begin
                        // any byte opens a frame
                        n_first_marker = rx;
                        n_cmd          = '0;
                        n_count        = '0;
                        n_length       = '0;
                        n_index        = '0;
                        n_crc_hi       = '0;
                        n_crc          = r_crc_init;
                        n_phase        = PH_MARK2;
                    end
                    PH_MARK2: begin
                        if (r_first_marker != MARK_FIRST || rx != MARK_SECOND) begin
                            res_valid  = 1'b1;
                            res.status = ST_BAD_MARKER;
                            n_phase    = PH_IDLE;
                        end else begin
                            n_crc   = crc_absorb(r_crc_aa, MARK_SECOND, r_crc_poly,
                                                 r_crc_reflect[0]);
                            n_phase = PH_CMD;
                        end
                    end
                    PH_CMD: begin
                        n_cmd   = rx;
                        n_crc   = crc_absorb(r_crc, rx, r_crc_poly, r_crc_reflect[0]);
                        n_phase = PH_COUNT;
                    end
                    PH_COUNT: begin
                        n_count = rx;
                        n_crc   = crc_absorb(r_crc, rx, r_crc_poly, r_crc_reflect[0]);
                        if (rx > r_max_args) begin
                            res_valid  = 1'b1;
                            res.status = ST_MANY_ARGS;
                            n_phase    = PH_IDLE;
                        end else begin
                            n_index = '0;
                            n_phase = (rx == '0) ? PH_LEN : PH_TYPES;
                        end
                    end
                    PH_TYPES: begin
                        if (rx < TYPE_MIN || rx > TYPE_MAX) begin
                            res_valid  = 1'b1;
                            res.status = ST_BAD_TYPE;
                            n_phase    = PH_IDLE;
                        end else begin
                            n_crc        = crc_absorb(r_crc, rx, r_crc_poly, r_crc_reflect[0]);
                            res_valid    = 1'b1;
                            res.kind     = KIND_TYPE;
                            res.value    = rx;
                            res.position = r_index;
                            n_index      = index_inc;
                            if (index_inc >= r_count) begin
                                n_phase = PH_LEN;
                            end
                        end
                    end
                    PH_LEN: begin
                        n_length = rx;
                        n_crc    = crc_absorb(r_crc, rx, r_crc_poly, r_crc_reflect[0]);
                        if (rx > r_max_payload) begin
                            res_valid  = 1'b1;
                            res.status = ST_LONG_PAY;
                            n_phase    = PH_IDLE;
                        end else begin
                            n_index = '0;
                            n_phase = (rx == '0) ? PH_CRC_HI : PH_PAYLOAD;
                        end
                    end
                    PH_PAYLOAD: begin
                        n_crc        = crc_absorb(r_crc, rx, r_crc_poly, r_crc_reflect[0]);
                        res_valid    = 1'b1;
                        res.kind     = KIND_PAYLOAD;
                        res.value    = rx;
                        res.position = r_index;
                        n_index      = index_inc;
                        if (index_inc >= r_length) begin
                            n_phase = PH_CRC_HI;
                        end
                    end
                    PH_CRC_HI: begin
                        n_crc_hi = rx;
                        n_phase  = PH_CRC_LO;
                    end
                    PH_CRC_LO: begin
                        res_valid        = 1'b1;
                        res.status       = (crc_rx == crc_calc) ? ST_OK : ST_CRC_ERR;
                        res.crc_received = crc_rx;
                        res.crc_computed = crc_calc;
                        n_phase          = PH_IDLE;
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
        end

        // frame header fields reflect this request's updates
        res.command   = n_cmd;
        res.arg_count = n_count;
        res.pay_len   = n_length;
    end

    // output register with skid
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_skid_valid = r_skid_valid;
        n_skid       = r_skid;
        if (pop) begin
            n_out_valid = r_skid_valid;
            n_out       = r_skid;
            n_skid_valid = 1'b0;
        end
        if (res_valid) begin
            if (!r_out_valid || pop) begin
                n_out_valid = 1'b1;
                n_out       = res;
            end else begin
                n_skid_valid = 1'b1;
                n_skid       = res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_args     <= RST_MAX_ARGS;
            r_max_payload  <= RST_MAX_PAYLOAD;
            r_timeout      <= RST_TIMEOUT;
            r_crc_poly     <= RST_CRC_POLY;
            r_crc_init     <= RST_CRC_INIT;
            r_crc_xorout   <= RST_CRC_XOROUT;
            r_crc_reflect  <= RST_CRC_REFLECT;
            r_crc_aa       <= crc_absorb(RST_CRC_INIT, MARK_FIRST, RST_CRC_POLY,
                                         RST_CRC_REFLECT[0]);
            r_phase        <= PH_IDLE;
            r_first_marker <= '0;
            r_crc          <= '0;
            r_cmd          <= '0;
            r_count        <= '0;
            r_length       <= '0;
            r_index        <= '0;
            r_crc_hi       <= '0;
            r_idle_ticks   <= '0;
            r_out_valid    <= 1'b0;
            r_skid_valid   <= 1'b0;
        end else begin
            r_max_args     <= n_max_args;
            r_max_payload  <= n_max_payload;
            r_timeout      <= n_timeout;
            r_crc_poly     <= n_crc_poly;
            r_crc_init     <= n_crc_init;
            r_crc_xorout   <= n_crc_xorout;
            r_crc_reflect  <= n_crc_reflect;
            // tracks the settings as they are written
            r_crc_aa       <= crc_absorb(n_crc_init, MARK_FIRST, n_crc_poly,
                                         n_crc_reflect[0]);
            r_phase        <= n_phase;
            r_first_marker <= n_first_marker;
            r_crc          <= n_crc;
            r_cmd          <= n_cmd;
            r_count        <= n_count;
            r_length       <= n_length;
            r_index        <= n_index;
            r_crc_hi       <= n_crc_hi;
            r_idle_ticks   <= n_idle_ticks;
            r_out_valid    <= n_out_valid;
            r_skid_valid   <= n_skid_valid;
        end
        r_out  <= n_out;
        r_skid <= n_skid;
    end

endmodule
